// ===== sv/dufc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dufc_pkg
// Types and constants shared by the double unpack and classify pipeline.
// ---------------------------------------------------------------------------
package dufc_pkg;

   localparam int FRAC_W     = 52;
   localparam int BEXP_W     = 11;
   localparam int EXP_W      = 12;
   localparam int SIG_W      = 61;
   localparam int NORM_SHIFT = 8;
   localparam int CHUNK_W    = 13;
   localparam int CHUNKS     = FRAC_W / CHUNK_W;
   localparam int CNT_W      = 4;
   localparam int LZ_W       = 6;

   localparam logic [BEXP_W-1:0]     BEXP_ALL_ONES = '1;
   localparam logic signed [EXP_W-1:0] EXP_BIAS    = 12'sd1023;
   // denormal exponent is -1022 minus (leading zeros of fraction + 1)
   localparam logic signed [EXP_W-1:0] DENORM_EXP_TOP = -12'sd1023;

   typedef enum logic [2:0] {
      CLS_SNAN   = 3'd0,
      CLS_QNAN   = 3'd1,
      CLS_ZERO   = 3'd2,
      CLS_FINITE = 3'd3,
      CLS_INF    = 3'd4
   } class_type;

   typedef struct packed {
      logic [31:0] high_word;
      logic [31:0] low_word;
   } req_payload_type;

   typedef struct packed {
      class_type               number_class;
      logic                    sign_bit;
      logic signed [EXP_W-1:0] true_exponent;
      logic [SIG_W-1:0]        significand;
   } rsp_payload_type;

   // stage 1 -> stage 2
   typedef struct packed {
      class_type               cls;
      logic                    sign;
      logic                    denorm;
      logic signed [EXP_W-1:0] exp_norm;
      logic [FRAC_W-1:0]       frac;
   } s1_type;

   // stage 2 -> stage 3
   typedef struct packed {
      class_type               cls;
      logic                    sign;
      logic                    denorm;
      logic signed [EXP_W-1:0] exp;
      logic [FRAC_W-1:0]       frac;
      logic [FRAC_W-1:0]       frac_coarse;
      logic [CNT_W-1:0]        fine;
   } s2_type;

endpackage

// ===== sv/dufc_lzc.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dufc_lzc
// Leading-zero count of one fraction chunk, with an all-zero flag.
// ---------------------------------------------------------------------------
module dufc_lzc
   import dufc_pkg::*;
(
   input  logic [CHUNK_W-1:0] chunk,
   output logic [CNT_W-1:0]   count,
   output logic               all_zero
);

   always_comb begin
      count = '0;
      // lowest to highest, so the top set bit wins
      for (int i = 0; i < CHUNK_W; i++) begin
         if (chunk[i]) begin
            count = CNT_W'(CHUNK_W - 1 - i);
         end
      end
      all_zero = ~|chunk;
   end

endmodule

// ===== sv/double_unpack_classify_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_unpack_classify_top
// Unpacks an IEEE-754 double into class, sign, unbiased exponent and a
// significand normalised to bit 60 (raw fraction for NaNs); denormals are
// normalised by a leading-zero count and a two-step shift.
//
//   channel | dir | beat contents
//   req_    | in  | high_word, low_word
//   rsp_    | out | number_class, sign_bit, true_exponent, significand
//
// Three register stages: decode and chunk zero count, coarse shift and
// exponent, fine shift into the output register. One beat per cycle is
// sustained while rsp_ready stays high.
// Reset clears the stage valid bits only. A response stall backs up the
// stages one by one; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module double_unpack_classify_top
   import dufc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic adv1, adv2, adv3;

   s1_type          s1_ff, s1_in;
   s2_type          s2_ff, s2_in;
   rsp_payload_type s3_ff, s3_in;

   logic [CHUNKS-1:0][CNT_W-1:0] lzc1_ff, lzc1_in;
   logic [CHUNKS-1:0]            nz1_ff, nz1_in;
   logic [CHUNKS-1:0]            zero_chunk;

   assign adv3      = !v3_ff || rsp_ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = v3_ff;
   assign rsp_payload = s3_ff;

   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   // ---------------- stage 1: decode ----------------
   logic [63:0]       bits;
   logic [BEXP_W-1:0] bexp;
   logic [FRAC_W-1:0] frac;

   assign bits = {req_payload.high_word, req_payload.low_word};
   assign bexp = bits[62:FRAC_W];
   assign frac = bits[FRAC_W-1:0];

   for (genvar c = 0; c < CHUNKS; c++) begin : g_lzc
      dufc_lzc u_lzc (
         .chunk    (frac[c*CHUNK_W +: CHUNK_W]),
         .count    (lzc1_in[c]),
         .all_zero (zero_chunk[c])
      );
   end
   assign nz1_in = ~zero_chunk;

   always_comb begin
      s1_in          = '0;
      s1_in.sign     = bits[63];
      s1_in.frac     = frac;
      s1_in.exp_norm = $signed({1'b0, bexp}) - EXP_BIAS;
      if (bexp == '0) begin
         s1_in.cls    = (frac == '0) ? CLS_ZERO : CLS_FINITE;
         s1_in.denorm = (frac != '0);
      end else if (bexp == BEXP_ALL_ONES) begin
         if (frac == '0) begin
            s1_in.cls = CLS_INF;
         end else begin
            s1_in.cls = frac[FRAC_W-1] ? CLS_QNAN : CLS_SNAN;
         end
      end else begin
         s1_in.cls = CLS_FINITE;
      end
   end

   // ---------------- stage 2: coarse shift, exponent ----------------
   always_comb begin
      logic [LZ_W-1:0] lz;
      lz                = '0;
      s2_in             = '0;
      s2_in.cls         = s1_ff.cls;
      s2_in.sign        = s1_ff.sign;
      s2_in.denorm      = s1_ff.denorm;
      s2_in.frac        = s1_ff.frac;
      s2_in.frac_coarse = s1_ff.frac;
      s2_in.fine        = lzc1_ff[CHUNKS-1];
      lz                = LZ_W'(lzc1_ff[CHUNKS-1]);
      // first non-empty chunk from the top picks the coarse shift
      for (int c = 0; c < CHUNKS - 1; c++) begin
         if (nz1_ff[c] && ((nz1_ff >> (c + 1)) == '0)) begin
            s2_in.frac_coarse = s1_ff.frac << ((CHUNKS - 1 - c) * CHUNK_W);
            s2_in.fine        = lzc1_ff[c];
            lz = LZ_W'((CHUNKS - 1 - c) * CHUNK_W) + LZ_W'(lzc1_ff[c]);
         end
      end
      if (s1_ff.denorm) begin
         s2_in.exp = DENORM_EXP_TOP - $signed({{(EXP_W-LZ_W){1'b0}}, lz});
      end else if (s1_ff.cls == CLS_FINITE) begin
         s2_in.exp = s1_ff.exp_norm;
      end else begin
         s2_in.exp = '0;
      end
   end

   // ---------------- stage 3: fine shift, format ----------------
   always_comb begin
      s3_in               = '0;
      s3_in.number_class  = s2_ff.cls;
      s3_in.sign_bit      = s2_ff.sign;
      s3_in.true_exponent = s2_ff.exp;
      case (s2_ff.cls)
         CLS_FINITE: begin
            if (s2_ff.denorm) begin
               s3_in.significand =
                  {s2_ff.frac_coarse, {(NORM_SHIFT+1){1'b0}}} << s2_ff.fine;
            end else begin
               s3_in.significand = {1'b1, s2_ff.frac, {NORM_SHIFT{1'b0}}};
            end
         end
         CLS_SNAN, CLS_QNAN: begin
            s3_in.significand = {{(SIG_W-FRAC_W){1'b0}}, s2_ff.frac};
         end
         default: begin
            s3_in.significand = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff   <= s1_in;
         lzc1_ff <= lzc1_in;
         nz1_ff  <= nz1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------- checks ----------------
   a_finite_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.number_class == CLS_FINITE
      |-> rsp_payload.significand[SIG_W-1])
      else $error("finite beat without leading bit");

   a_zero_inf_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.number_class == CLS_ZERO ||
                    rsp_payload.number_class == CLS_INF)
      |-> rsp_payload.true_exponent == '0 && rsp_payload.significand == '0)
      else $error("zero or infinity carries exponent or significand");

   a_nan_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.number_class == CLS_SNAN ||
                    rsp_payload.number_class == CLS_QNAN)
      |-> rsp_payload.true_exponent == '0 &&
          rsp_payload.significand[SIG_W-1:FRAC_W] == '0 &&
          rsp_payload.significand[FRAC_W-1:0] != '0)
      else $error("NaN beat malformed");

   a_stage2_held: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !adv2 |=> v2_ff && $stable(s2_ff))
      else $error("stage 2 lost a beat under stall");

endmodule
